@@ sv/assert_macros.svh @@
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ sv/ipwd_pkg.sv @@
// Shared types and constants of the IR pulse-width decoder.
`timescale 1ns / 1ps
package ipwd_pkg;

  localparam int TICK_W     = 15;          // tick count width
  localparam int X_W        = TICK_W + 4;  // ticks * 10
  localparam int US_W       = 16;          // nominal length width
  localparam int TOL_W      = 9;           // tolerance width
  localparam int WIN_W      = 17;          // window bound width, up to 65535 + 511 + 1
  localparam int WIN_MAX    = 66047;       // largest exclusive upper window bound
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 32;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [US_W-1:0]  RST_HDR_MARK  = 16'd9000;
  localparam logic [US_W-1:0]  RST_HDR_SPACE = 16'd4500;
  localparam logic [TOL_W-1:0] RST_HDR_TOL   = 9'd200;
  localparam logic [US_W-1:0]  RST_BIT_MARK  = 16'd560;
  localparam logic [US_W-1:0]  RST_ZERO_SPC  = 16'd560;
  localparam logic [US_W-1:0]  RST_ONE_SPC   = 16'd1690;
  localparam logic [TOL_W-1:0] RST_BIT_TOL   = 9'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HDR_MARK  = 3'd0,
    REG_HDR_SPACE = 3'd1,
    REG_HDR_TOL   = 3'd2,
    REG_BIT_MARK  = 3'd3,
    REG_ZERO_SPC  = 3'd4,
    REG_ONE_SPC   = 3'd5,
    REG_BIT_TOL   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [US_W-1:0]  hdr_mark;
    logic [US_W-1:0]  hdr_space;
    logic [TOL_W-1:0] hdr_tol;
    logic [US_W-1:0]  bit_mark;
    logic [US_W-1:0]  zero_space;
    logic [US_W-1:0]  one_space;
    logic [TOL_W-1:0] bit_tol;
  } cfg_t;

  // Classified pulse handed from the front end to the accumulator.
  typedef struct packed {
    logic last;       // final pulse of the frame
    logic hdr_fit;    // pulse fits the header window
    logic shift_en;   // pulse fits a data bit window
    logic shift_bit;  // value of that data bit
  } cls_t;

endpackage

@@ sv/ipwd_front.sv @@
// Front end: scales tick counts and classifies each pulse against the windows.
`timescale 1ns / 1ps
module ipwd_front #(
  parameter int TICKS_PER_10US = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ipwd_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ipwd_pkg::TICK_W-1:0] mark_ticks,
  input  logic [ipwd_pkg::TICK_W-1:0] space_ticks,
  input  logic                        in_last,
  output logic                        q_valid,
  input  logic                        q_ready,
  output ipwd_pkg::cls_t              q_cls
);
  import ipwd_pkg::*;

  localparam int THR_W = $clog2(WIN_MAX * TICKS_PER_10US + 1);
  localparam int CMP_W = (THR_W > X_W) ? THR_W : X_W;
  localparam logic [CMP_W-1:0] DIV_C = CMP_W'(TICKS_PER_10US);

  // Lower window bound, saturating at zero.
  function automatic logic [WIN_W-1:0] win_lo(logic [US_W-1:0] n, logic [TOL_W-1:0] t);
    logic [WIN_W-1:0] r;
    if (WIN_W'(n) >= WIN_W'(t)) begin
      r = WIN_W'(n) - WIN_W'(t);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Exclusive upper window bound.
  function automatic logic [WIN_W-1:0] win_hi(logic [US_W-1:0] n, logic [TOL_W-1:0] t);
    return WIN_W'(n) + WIN_W'(t) + WIN_W'(1);
  endfunction

  // floor(x / D) in [lo, hi) is the same as x in [lo * D, hi * D), so the
  // bounds are scaled once and no division is needed per pulse.
  logic [CMP_W-1:0] hm_lo_r, hm_hi_r, hs_lo_r, hs_hi_r;
  logic [CMP_W-1:0] bm_lo_r, bm_hi_r, zs_lo_r, zs_hi_r, os_lo_r, os_hi_r;

  always_ff @(posedge clk) begin
    hm_lo_r <= CMP_W'(win_lo(cfg.hdr_mark, cfg.hdr_tol)) * DIV_C;
    hm_hi_r <= CMP_W'(win_hi(cfg.hdr_mark, cfg.hdr_tol)) * DIV_C;
    hs_lo_r <= CMP_W'(win_lo(cfg.hdr_space, cfg.hdr_tol)) * DIV_C;
    hs_hi_r <= CMP_W'(win_hi(cfg.hdr_space, cfg.hdr_tol)) * DIV_C;
    bm_lo_r <= CMP_W'(win_lo(cfg.bit_mark, cfg.bit_tol)) * DIV_C;
    bm_hi_r <= CMP_W'(win_hi(cfg.bit_mark, cfg.bit_tol)) * DIV_C;
    zs_lo_r <= CMP_W'(win_lo(cfg.zero_space, cfg.bit_tol)) * DIV_C;
    zs_hi_r <= CMP_W'(win_hi(cfg.zero_space, cfg.bit_tol)) * DIV_C;
    os_lo_r <= CMP_W'(win_lo(cfg.one_space, cfg.bit_tol)) * DIV_C;
    os_hi_r <= CMP_W'(win_hi(cfg.one_space, cfg.bit_tol)) * DIV_C;
  end

  // Stage one: ticks times ten.
  logic           s1_valid_r, s1_valid_nxt;
  logic [X_W-1:0] s1_mark_r, s1_space_r;
  logic           s1_last_r;
  // Stage two: classified pulse.
  logic           s2_valid_r, s2_valid_nxt;
  cls_t           s2_cls_r, s2_cls_nxt;

  logic s1_free, s2_free, s1_load, s2_load;
  logic [CMP_W-1:0] mark_x, space_x;
  logic space_zero, hm_ok, hs_ok, bm_ok, zs_ok, os_ok, zero_fit, one_fit;

  assign s2_free  = !s2_valid_r || q_ready;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;
  assign s1_load  = in_valid && s1_free;
  assign s2_load  = s1_valid_r && s2_free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_valid;
    end
    s2_valid_nxt = s2_valid_r;
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mark_r  <= X_W'({mark_ticks, 3'b000}) + X_W'({mark_ticks, 1'b0});
      s1_space_r <= X_W'({space_ticks, 3'b000}) + X_W'({space_ticks, 1'b0});
      s1_last_r  <= in_last;
    end
    if (s2_load) begin
      s2_cls_r <= s2_cls_nxt;
    end
  end

  always_comb begin
    mark_x     = CMP_W'(s1_mark_r);
    space_x    = CMP_W'(s1_space_r);
    space_zero = space_x < DIV_C;
    hm_ok      = (mark_x >= hm_lo_r) && (mark_x < hm_hi_r);
    hs_ok      = (space_x >= hs_lo_r) && (space_x < hs_hi_r);
    bm_ok      = (mark_x >= bm_lo_r) && (mark_x < bm_hi_r);
    zs_ok      = (space_x >= zs_lo_r) && (space_x < zs_hi_r);
    os_ok      = (space_x >= os_lo_r) && (space_x < os_hi_r);
    zero_fit   = bm_ok && (space_zero || zs_ok);
    one_fit    = bm_ok && (space_zero || os_ok);
    s2_cls_nxt.last      = s1_last_r;
    s2_cls_nxt.hdr_fit   = hm_ok && (space_zero || hs_ok);
    s2_cls_nxt.shift_en  = zero_fit || one_fit;
    s2_cls_nxt.shift_bit = !zero_fit;
  end

  assign q_valid = s2_valid_r;
  assign q_cls   = s2_cls_r;

endmodule

@@ sv/ipwd_fifo.sv @@
// Short queue of classified pulses between the front end and the accumulator.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipwd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  ipwd_pkg::cls_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output ipwd_pkg::cls_t rd_data
);
  import ipwd_pkg::*;

  cls_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               push, pop;

  assign wr_ready = count_r != Q_CNT_W'(Q_DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `ASSERT_NEVER(a_fifo_bound, clk, rst_n, count_r > Q_CNT_W'(Q_DEPTH), "fifo count beyond depth")
  `ASSERT_CLK(a_fifo_inc, clk, rst_n, (push && !pop) |=> count_r == $past(count_r) + 1'b1, "fifo count did not rise on push")
  `ASSERT_CLK(a_fifo_dec, clk, rst_n, (pop && !push) |=> count_r == $past(count_r) - 1'b1, "fifo count did not fall on pop")

endmodule

@@ sv/ipwd_back.sv @@
// Back end: frame state, bit accumulator and the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ipwd_back #(
  parameter int CODE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  ipwd_pkg::cls_t             q_cls,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ipwd_pkg::OUT_W-1:0] out_code,
  output logic                       out_hdr_good
);
  import ipwd_pkg::*;

  logic                  at_start_r, at_start_nxt;
  logic                  hdr_seen_r, hdr_seen_nxt;
  logic [CODE_WIDTH-1:0] acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_code_r, out_code_nxt;
  logic                  out_hdr_r, out_hdr_nxt;

  logic                  out_free, pop, hdr_now;
  logic [CODE_WIDTH-1:0] acc_sh;

  // A last pulse needs room in the result register; others never wait.
  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = !q_cls.last || out_free;
  assign pop      = q_valid && q_ready;

  always_comb begin
    hdr_now = at_start_r ? q_cls.hdr_fit : hdr_seen_r;
    acc_sh  = q_cls.shift_en ? {acc_r[CODE_WIDTH-2:0], q_cls.shift_bit} : acc_r;

    at_start_nxt  = at_start_r;
    hdr_seen_nxt  = hdr_seen_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_code_nxt  = out_code_r;
    out_hdr_nxt   = out_hdr_r;
    if (pop) begin
      if (q_cls.last) begin
        at_start_nxt  = 1'b1;
        hdr_seen_nxt  = 1'b0;
        acc_nxt       = '0;
        out_valid_nxt = 1'b1;
        out_code_nxt  = hdr_now ? OUT_W'(acc_sh) : '0;
        out_hdr_nxt   = hdr_now;
      end else begin
        at_start_nxt = 1'b0;
        hdr_seen_nxt = hdr_now;
        acc_nxt      = acc_sh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      hdr_seen_r  <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      at_start_r  <= at_start_nxt;
      hdr_seen_r  <= hdr_seen_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_hdr_r  <= out_hdr_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_code     = out_code_r;
  assign out_hdr_good = out_hdr_r;

  `ASSERT_CLK(a_last_loads_out, clk, rst_n, (pop && q_cls.last) |=> out_valid_r, "last pulse did not load a result")
  `ASSERT_CLK(a_last_clears, clk, rst_n, (pop && q_cls.last) |=> (at_start_r && !hdr_seen_r && acc_r == '0), "frame state not cleared after last pulse")
  `ASSERT_CLK(a_mid_pulse, clk, rst_n, (pop && !q_cls.last) |=> !at_start_r, "frame start flag kept after a pulse")
  `ASSERT_NEVER(a_bad_hdr_code, clk, rst_n, out_valid_r && !out_hdr_r && out_code_r != '0, "nonzero code on a bad header")

endmodule

@@ sv/ir_pulse_width_decoder.sv @@
// Top level of the IR pulse-width decoder: configuration registers and channel packing.
`timescale 1ns / 1ps
// Decodes pulse-width remote control frames from captured pulses.
// Input channel (in_*): one word per pulse, mark and space durations in capture
// ticks, with in_tlast set on the final pulse of a frame. A space of zero means
// the space was not terminated and always fits. Output channel (out_*): one word
// per frame, the accumulated code with the newest bit in bit 0, and in out_tuser
// whether the frame's first pulse fit the header window; the code is zero when
// it did not. Pulses that fit no bit window are dropped from the code.
// Configuration channel (cfg_*): register index on cfg_addr and value on
// cfg_data, always ready; write only while no frame is in flight.
// Throughput: one pulse per clock while results are taken. The front end takes two
// register stages to scale the tick counts and compare them with the windows, a
// four-word queue then feeds the accumulator, which handles one pulse per clock
// unless a last pulse waits for room in the result register. The last pulse of a
// frame passes the two front stages and the queue before the accumulator loads
// the result register and out_tvalid rises. When out_tready is low the result
// stays in the output register; pulses keep flowing until a second last pulse
// arrives, then the queue and the two front stages fill and in_tready drops.
// Reset restores the default windows, empties the pipeline and starts a new frame.
module ir_pulse_width_decoder #(
  parameter int TICKS_PER_10US = 8,
  parameter int CODE_WIDTH     = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // [14:0] mark_ticks, [29:15] space_ticks, [31:30] zero
  input  logic                            in_tlast,   // frame_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [31:0] code
  output logic                            out_tuser,  // [0] header_good
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipwd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ipwd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipwd_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_valid, q_ready, fe_valid, fe_ready;
  cls_t fe_cls, q_cls;

  assign cfg_ready = 1'b1;

  // Writes to the unused index are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_addr)
        REG_HDR_MARK:  cfg_nxt.hdr_mark   = cfg_data;
        REG_HDR_SPACE: cfg_nxt.hdr_space  = cfg_data;
        REG_HDR_TOL:   cfg_nxt.hdr_tol    = cfg_data[TOL_W-1:0];
        REG_BIT_MARK:  cfg_nxt.bit_mark   = cfg_data;
        REG_ZERO_SPC:  cfg_nxt.zero_space = cfg_data;
        REG_ONE_SPC:   cfg_nxt.one_space  = cfg_data;
        REG_BIT_TOL:   cfg_nxt.bit_tol    = cfg_data[TOL_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_mark   <= RST_HDR_MARK;
      cfg_r.hdr_space  <= RST_HDR_SPACE;
      cfg_r.hdr_tol    <= RST_HDR_TOL;
      cfg_r.bit_mark   <= RST_BIT_MARK;
      cfg_r.zero_space <= RST_ZERO_SPC;
      cfg_r.one_space  <= RST_ONE_SPC;
      cfg_r.bit_tol    <= RST_BIT_TOL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ipwd_front #(
    .TICKS_PER_10US(TICKS_PER_10US)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .mark_ticks (in_tdata[TICK_W-1:0]),
    .space_ticks(in_tdata[2*TICK_W-1:TICK_W]),
    .in_last    (in_tlast),
    .q_valid    (fe_valid),
    .q_ready    (fe_ready),
    .q_cls      (fe_cls)
  );

  ipwd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fe_valid),
    .wr_ready(fe_ready),
    .wr_data (fe_cls),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_data (q_cls)
  );

  ipwd_back #(
    .CODE_WIDTH(CODE_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cls       (q_cls),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_code    (out_tdata),
    .out_hdr_good(out_tuser)
  );

endmodule
